FILE: hw/rtl/ccp_pkg.sv
package ccp_pkg;

    localparam int CELL_ROWS = 8;
    localparam int ROW_W     = $clog2(CELL_ROWS);
    localparam int NUM_SLOTS = 4;

    localparam logic [7:0] SLOT_FREE = 8'd255;

    // operation codes
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_SET   = 2'd1;
    localparam logic [1:0] OP_GET   = 2'd2;
    localparam logic [1:0] OP_REORG = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_PIXEL_MASK   = 3'd0;
    localparam logic [2:0] CFG_MAX_COLORS   = 3'd1;
    localparam logic [2:0] CFG_MIN_COLOR    = 3'd2;
    localparam logic [2:0] CFG_PIXEL_SCALE  = 3'd3;
    localparam logic [2:0] CFG_FORCE_ENABLE = 3'd4;
    localparam logic [2:0] CFG_FORCE_COLOR  = 3'd5;

    typedef struct packed {
        logic [1:0] op;
        logic [2:0] bit_pos;
        logic [2:0] row;
        logic [7:0] color;
        logic [7:0] bg_color;
    } t_in_item;

    typedef struct packed {
        logic [7:0] pixel_color;
        logic [1:0] slot_index;
        logic [7:0] row_bits;
        logic [7:0] slot0_color;
        logic [7:0] slot1_color;
        logic [7:0] slot2_color;
        logic [7:0] slot3_color;
    } t_out_item;

    typedef struct packed {
        logic             take;
        logic             clear_row;
        logic             set_en;
        logic             scan;
        logic             final_en;
        logic             load_result;
        logic [ROW_W-1:0] row_idx;
    } t_cmd;

    typedef logic [NUM_SLOTS-1:0][7:0] t_slots;

    // slot limit: max_colors saturated to 1..4
    function automatic logic [2:0] f_lim(input logic [2:0] max_colors);
        logic [2:0] m;
        m = max_colors;
        if (m < 3'd1) m = 3'd1;
        if (m > 3'd4) m = 3'd4;
        return m;
    endfunction

    // pixel field at bit offset x, masked
    function automatic logic [1:0] f_field(input logic [7:0] row, input logic [2:0] x,
                                           input logic [1:0] mask);
        logic [8:0] ext;
        ext = {1'b0, row} >> x;
        return ext[1:0] & mask;
    endfunction

    // slots referenced by the sampled positions of one row
    function automatic logic [3:0] f_used(input logic [7:0] row, input logic [1:0] mask,
                                          input logic [1:0] scale);
        logic [3:0] used;
        logic       take_pos;
        logic [1:0] v;
        used = '0;
        for (int p = 0; p < 8; p++) begin
            unique case (scale)
                2'd2:    take_pos = (p % 2 == 0);
                2'd3:    take_pos = (p == 0) || (p == 3);
                default: take_pos = 1'b1;
            endcase
            v = f_field(row, 3'(p), mask);
            if (take_pos) used[v] = 1'b1;
        end
        return used;
    endfunction

    // map 2-bit fields 1 and/or 2 onto 3
    function automatic logic [7:0] f_remap(input logic [7:0] row, input logic map1,
                                           input logic map2);
        logic [7:0] nv;
        logic [1:0] v;
        nv = '0;
        for (int j = 0; j < 4; j++) begin
            v = row[2*j +: 2];
            if (map1 && v == 2'd1) v = 2'd3;
            if (map2 && v == 2'd2) v = 2'd3;
            nv[2*j +: 2] = v;
        end
        return nv;
    endfunction

endpackage

FILE: hw/rtl/ccp_ctrl.sv
module ccp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [1:0]    i_op,
    output logic          o_in_ready,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output ccp_pkg::t_cmd o_cmd
);
    import ccp_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_CLEAR  = 6'b000010,
        S_SET    = 6'b000100,
        S_SCAN   = 6'b001000,
        S_FINAL  = 6'b010000,
        S_RESULT = 6'b100000
    } t_state;

    t_state           r_state, n_state;
    logic [ROW_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             cnt_last;

    assign cnt_last    = (r_cnt == ROW_W'(CELL_ROWS - 1));
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.row_idx = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_cnt      = '0;
                    unique case (i_op)
                        OP_CLEAR: n_state = S_CLEAR;
                        OP_SET:   n_state = S_SET;
                        OP_GET:   n_state = S_RESULT;
                        OP_REORG: n_state = S_SCAN;
                    endcase
                end
            end
            S_CLEAR: begin
                o_cmd.clear_row = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (cnt_last) n_state = S_RESULT;
            end
            S_SET: begin
                o_cmd.set_en = 1'b1;
                n_state = S_RESULT;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (cnt_last) n_state = S_FINAL;
            end
            S_FINAL: begin
                o_cmd.final_en = 1'b1;
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_result = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_result) n_out_valid = 1'b1;
        else if (i_out_ready)  n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: hw/rtl/ccp_dpath.sv
module ccp_dpath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ccp_pkg::t_cmd     i_cmd,
    input  ccp_pkg::t_in_item i_in,
    input  logic              i_cfg_valid,
    input  logic [2:0]        i_cfg_index,
    input  logic [7:0]        i_cfg_data,
    output ccp_pkg::t_out_item o_out
);
    import ccp_pkg::*;

    // configuration
    logic [1:0] r_pixel_mask;
    logic [2:0] r_max_colors;
    logic [1:0] r_min_color;
    logic [1:0] r_pixel_scale;
    logic       r_force_enable;
    logic [7:0] r_force_color;

    // latched item
    t_in_item r_item;

    // cell state
    logic [CELL_ROWS-1:0][7:0] r_bitmap;
    t_slots                    r_slots, n_slots;
    logic [3:0]                r_used, n_used;
    logic [1:0]                r_win, n_win;
    t_out_item                 r_out, n_out;

    logic [ROW_W-1:0] rd_addr;
    logic [7:0]       rd_row;
    logic [7:0]       wr_row;
    logic             wr_en;
    logic [2:0]       lim;
    logic [1:0]       cur;

    assign lim     = f_lim(r_max_colors);
    assign rd_addr = i_cmd.scan ? i_cmd.row_idx : r_item.row;
    assign rd_row  = r_bitmap[rd_addr];
    assign cur     = f_field(rd_row, r_item.bit_pos, r_pixel_mask);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_mask   <= 2'd3;
            r_max_colors   <= 3'd4;
            r_min_color    <= 2'd1;
            r_pixel_scale  <= 2'd2;
            r_force_enable <= 1'b0;
            r_force_color  <= 8'd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PIXEL_MASK:   r_pixel_mask   <= i_cfg_data[1:0];
                CFG_MAX_COLORS:   r_max_colors   <= i_cfg_data[2:0];
                CFG_MIN_COLOR:    r_min_color    <= i_cfg_data[1:0];
                CFG_PIXEL_SCALE:  r_pixel_scale  <= i_cfg_data[1:0];
                CFG_FORCE_ENABLE: r_force_enable <= i_cfg_data[0];
                CFG_FORCE_COLOR:  r_force_color  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // slot update, row write and usage collection
    always_comb begin
        logic       hit;
        logic       found;
        logic [1:0] lo;
        logic [7:0] tmp;
        logic [9:0] v;
        logic [7:0] remapped;

        n_slots  = r_slots;
        n_used   = r_used;
        n_win    = r_win;
        wr_en    = 1'b0;
        wr_row   = rd_row;
        hit      = 1'b0;
        found    = 1'b0;
        lo       = '0;
        tmp      = '0;
        v        = '0;
        remapped = f_remap(rd_row,
                           r_force_enable && (r_slots[1] == r_force_color),
                           r_force_enable && (r_slots[2] == r_force_color));

        if (i_cmd.take) n_used = '0;

        if (i_cmd.clear_row) begin
            wr_en      = 1'b1;
            wr_row     = '0;
            n_slots    = {SLOT_FREE, SLOT_FREE, SLOT_FREE, r_item.bg_color};
        end

        if (i_cmd.set_en) begin
            if (r_max_colors == 3'd2) begin
                // hires: slot 0 preferred, then slot 1, else the pixel's own slot
                if (r_slots[1] == r_item.color || r_slots[1] == SLOT_FREE) begin
                    n_win = 2'd1;
                    found = 1'b1;
                end
                if (r_slots[0] == r_item.color || r_slots[0] == SLOT_FREE) begin
                    n_win = 2'd0;
                    found = 1'b1;
                end
                if (found) begin
                    if (r_slots[n_win] == SLOT_FREE) n_slots[n_win] = r_item.color;
                end else begin
                    n_win = cur;
                    n_slots[n_win] = r_item.color;
                end
            end else begin
                n_win = 2'(lim - 3'd1);
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (!hit && 3'(i) < lim && r_slots[i] == r_item.color) begin
                        hit   = 1'b1;
                        n_win = 2'(i);
                    end
                end
                if (!hit) begin
                    for (int i = 0; i < NUM_SLOTS; i++) begin
                        if (!found && 2'(i) >= r_min_color && 3'(i) < lim
                            && r_slots[i] == SLOT_FREE) begin
                            found = 1'b1;
                            n_win = 2'(i);
                        end
                    end
                    if (n_win >= r_min_color) n_slots[n_win] = r_item.color;
                end
                if (r_force_enable) n_slots[3] = r_force_color;
            end
            v = ({2'b00, rd_row} & ~({8'd0, r_pixel_mask} << r_item.bit_pos))
                | ({8'd0, n_win} << r_item.bit_pos);
            wr_en  = 1'b1;
            wr_row = v[7:0];
        end

        if (i_cmd.scan) begin
            wr_en  = 1'b1;
            wr_row = remapped;
            n_used = r_used | f_used(remapped, r_pixel_mask, r_pixel_scale);
        end

        if (i_cmd.final_en) begin
            if (r_force_enable) n_slots[3] = r_force_color;
            // bring the background into slot 0
            if (n_slots[0] != r_item.bg_color) begin
                for (int i = 1; i < NUM_SLOTS; i++) begin
                    if (3'(i) < lim && n_slots[i] == r_item.bg_color) begin
                        tmp        = n_slots[0];
                        n_slots[0] = n_slots[i];
                        n_slots[i] = tmp;
                    end
                end
            end
            // free slots from min_color (at least 1) below the limit that no sampled pixel refers to
            lo = (r_min_color < 2'd1) ? 2'd1 : r_min_color;
            for (int i = 1; i < NUM_SLOTS; i++) begin
                if (2'(i) >= lo && 3'(i) < lim && !r_used[i]) n_slots[i] = SLOT_FREE;
            end
        end
    end

    always_comb begin
        n_out = r_out;
        if (i_cmd.load_result) begin
            n_out.pixel_color = r_slots[cur];
            n_out.slot_index  = (r_item.op == OP_SET) ? r_win : cur;
            n_out.row_bits    = rd_row;
            n_out.slot0_color = r_slots[0];
            n_out.slot1_color = r_slots[1];
            n_out.slot2_color = r_slots[2];
            n_out.slot3_color = r_slots[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bitmap <= '0;
            r_slots  <= {SLOT_FREE, SLOT_FREE, SLOT_FREE, 8'd0};
        end else begin
            if (wr_en) begin
                r_bitmap[i_cmd.clear_row ? i_cmd.row_idx : rd_addr] <= wr_row;
            end
            r_slots <= n_slots;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) r_item <= i_in;
        r_used <= n_used;
        r_win  <= n_win;
        r_out  <= n_out;
    end

    assign o_out = r_out;

endmodule

FILE: hw/rtl/char_cell_palette_slot_plotter_core.sv
// Character cell palette slot plotter.
// One 8x8 cell: eight bitmap rows plus four color slots (255 marks a free slot).
// Channels:
//   in  : i_in_valid / o_in_ready, payload i_in (op, bit_pos, row, color, bg_color)
//   out : o_out_valid / i_out_ready, payload o_out (pixel color, slot, row, slots)
//   cfg : i_cfg_valid / o_cfg_ready, i_cfg_index selects the register, i_cfg_data
//         carries the value; o_cfg_ready is always high.
// Every transfer on the input side yields exactly one output transfer.
// Work per item before its result is registered, with a free output:
//   get only reads, set writes the pixel into its row and updates the slots,
//   clear clears one row per cycle, reorganize remaps one row and checks it for
//   slot usage per cycle, then updates the slots. The row sweep of clear and
//   reorganize sets the rate; one item is in work at a time, and a new item is
//   taken as soon as the previous result sits in the output register.
// When the receiver stalls, the result holds in the output register and the
// block waits with its next result until that register drains.
// Reset (synchronous, active low) clears the bitmap, sets slot 0 to 0 and
// frees slots 1 to 3, and restores the configuration defaults.
module char_cell_palette_slot_plotter_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ccp_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ccp_pkg::t_out_item o_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_data
);
    import ccp_pkg::*;

    t_cmd cmd;

    // configuration writes land at once
    assign o_cfg_ready = 1'b1;

    ccp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_op        (i_in.op),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    ccp_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in        (i_in),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out       (o_out)
    );

    // a result is loaded only while an item is in work
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_result |-> !o_in_ready)
        else $error("result loaded while idle");

    // a loaded result is offered in the next cycle
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_result |=> o_out_valid)
        else $error("loaded result not offered");

    // no row or slot work while idle
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !(cmd.clear_row || cmd.set_en || cmd.scan || cmd.final_en))
        else $error("datapath busy while idle");

    // a get finishes right after its transfer unless the output is blocked
    a_get_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in.op == OP_GET)
        |=> (cmd.load_result || (o_out_valid && !i_out_ready)))
        else $error("get result delayed");

endmodule
